// ===== rtl/fan_tach_pkg.sv =====
// ----------------------------------------------------------------------------
// fan tach package
// shared widths, constants, register indexes and payload types of the
// fan tachometer rpm meter
// ----------------------------------------------------------------------------
package fan_tach_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int PIN_WIDTH           = 16;
   localparam int MS_WIDTH            = 32;
   localparam int PPR_WIDTH           = 8;
   localparam int WIN_WIDTH           = 16;
   localparam int RPM_WIDTH           = 32;
   localparam int SCALE_WIDTH         = 16;
   localparam int DEN_WIDTH           = MS_WIDTH + PPR_WIDTH;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int CSR_DATA_WIDTH      = 16;

   localparam logic [SCALE_WIDTH-1:0] RPM_MS_PER_MIN = 16'd60000;
   localparam logic [WIN_WIDTH-1:0]   WINDOW_RESET   = 16'd1000;
   localparam logic [PPR_WIDTH-1:0]   PPR_RESET      = 8'd2;
   localparam logic [PIN_WIDTH-1:0]   PIN_RESET      = 16'd0;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TACH_PIN_ID    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PULSES_PER_REV = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_MS      = 2'd2;

   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_POLL = 1'b1;

   typedef struct packed {
      logic                 cmd;
      logic [PIN_WIDTH-1:0] pin;
      logic [MS_WIDTH-1:0]  now_ms;
   } req_payload_type;

   typedef struct packed {
      logic [RPM_WIDTH-1:0] rpm;
      logic                 updated;
   } rsp_payload_type;

endpackage

// ===== rtl/fan_tach_rpm_meter.sv =====
// ----------------------------------------------------------------------------
// fan tach rpm meter
// counts tach pulses and measures fan speed in rpm on millisecond polls
// ----------------------------------------------------------------------------
// usage:
//  req channel (valid/stall): cmd 0 is a falling edge on pin, counted when pin
//   matches tach_pin_id; cmd 1 is a poll carrying now_ms.
//  rsp channel (valid/stall): one transaction per request with the held rpm
//   and updated set when that poll made a new measurement.
//  csr channel (valid/ready): index 0 tach_pin_id, 1 pulses_per_rev,
//   2 window_ms; ready is always high, other indexes are ignored.
//  path: an edge or an early poll goes through the done state into the
//   output register; a measuring poll goes through the multiply, divider
//   start, divider wait and done states, the one-bit-per-cycle divider
//   running over the COUNT_WIDTH + 16 bit numerator.
//  throughput: one request at a time; req_stall is high while a request is
//   at work, so a new request is not taken before the last is through. A
//   request may be accepted while the previous response waits.
//  reset: counts, last time and rpm clear to 0, registers take their defaults.
//  rsp_stall: the response holds in its register and a finished request
//   waits until that register frees.
// ----------------------------------------------------------------------------
module fan_tach_rpm_meter #(
   parameter int COUNT_WIDTH = fan_tach_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  fan_tach_pkg::req_payload_type           req_payload,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output fan_tach_pkg::rsp_payload_type           rsp_payload,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [fan_tach_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [fan_tach_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import fan_tach_pkg::*;

   localparam int NUM_WIDTH = COUNT_WIDTH + SCALE_WIDTH;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_MUL       = 3'd1;
   localparam logic [2:0] ST_DIV_START = 3'd2;
   localparam logic [2:0] ST_DIV_WAIT  = 3'd3;
   localparam logic [2:0] ST_DONE      = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [PIN_WIDTH-1:0]   tach_pin_ff, tach_pin_in;
   logic [PPR_WIDTH-1:0]   ppr_ff, ppr_in;
   logic [WIN_WIDTH-1:0]   window_ff, window_in;
   logic [COUNT_WIDTH-1:0] pulse_total_ff, pulse_total_in;
   logic [COUNT_WIDTH-1:0] pulses_at_last_ff, pulses_at_last_in;
   logic [MS_WIDTH-1:0]    time_at_last_ff, time_at_last_in;
   logic [RPM_WIDTH-1:0]   rpm_held_ff, rpm_held_in;
   logic                   upd_ff, upd_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [MS_WIDTH-1:0]    elapsed_ff, elapsed_in;
   logic [MS_WIDTH-1:0]    now_ff, now_in;
   logic [NUM_WIDTH-1:0]   num_ff, num_in;
   logic [DEN_WIDTH-1:0]   den_ff, den_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_payload_ff, rsp_payload_in;

   logic                   req_accept;
   logic [WIN_WIDTH-1:0]   win_eff;
   logic [PPR_WIDTH-1:0]   ppr_eff;
   logic [MS_WIDTH-1:0]    elapsed_now;
   logic                   due;
   logic                   div_start;
   logic                   div_done;
   logic [NUM_WIDTH-1:0]   div_quotient;
   logic [RPM_WIDTH-1:0]   rpm_value;

   fan_tach_divider #(
      .NUM_WIDTH (NUM_WIDTH),
      .DEN_WIDTH (DEN_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   generate
      if (NUM_WIDTH > RPM_WIDTH) begin : g_sat
         assign rpm_value = (|div_quotient[NUM_WIDTH-1:RPM_WIDTH]) ? '1
                                                                   : div_quotient[RPM_WIDTH-1:0];
      end else begin : g_nosat
         assign rpm_value = RPM_WIDTH'(div_quotient);
      end
   endgenerate

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign csr_ready   = 1'b1;
   assign win_eff     = (window_ff == '0) ? WIN_WIDTH'(1) : window_ff;
   assign ppr_eff     = (ppr_ff == '0) ? PPR_WIDTH'(1) : ppr_ff;
   assign elapsed_now = req_payload.now_ms - time_at_last_ff;
   assign due         = elapsed_now >= MS_WIDTH'(win_eff);
   assign div_start   = (state_ff == ST_DIV_START);

   // configuration decode
   always_comb begin
      tach_pin_in = tach_pin_ff;
      ppr_in      = ppr_ff;
      window_in   = window_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TACH_PIN_ID:    tach_pin_in = csr_data[PIN_WIDTH-1:0];
            CSR_PULSES_PER_REV: ppr_in      = csr_data[PPR_WIDTH-1:0];
            CSR_WINDOW_MS:      window_in   = csr_data[WIN_WIDTH-1:0];
            default:            ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in          = state_ff;
      pulse_total_in    = pulse_total_ff;
      pulses_at_last_in = pulses_at_last_ff;
      time_at_last_in   = time_at_last_ff;
      rpm_held_in       = rpm_held_ff;
      upd_in            = upd_ff;
      count_in          = count_ff;
      elapsed_in        = elapsed_ff;
      now_in            = now_ff;
      num_in            = num_ff;
      den_in            = den_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_payload_in    = rsp_payload_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               upd_in     = 1'b0;
               count_in   = COUNT_WIDTH'(pulse_total_ff - pulses_at_last_ff);
               elapsed_in = elapsed_now;
               now_in     = req_payload.now_ms;
               state_in   = ST_DONE;
               if (req_payload.cmd == CMD_EDGE) begin
                  if (req_payload.pin == tach_pin_ff) begin
                     pulse_total_in = COUNT_WIDTH'(pulse_total_ff + 1'b1);
                  end
               end else if (due) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            num_in   = NUM_WIDTH'(count_ff) * NUM_WIDTH'(RPM_MS_PER_MIN);
            den_in   = DEN_WIDTH'(elapsed_ff) * DEN_WIDTH'(ppr_eff);
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               rpm_held_in       = rpm_value;
               pulses_at_last_in = pulse_total_ff;
               time_at_last_in   = now_ff;
               upd_in            = 1'b1;
               state_in          = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_payload_in.rpm     = rpm_held_ff;
               rsp_payload_in.updated = upd_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         tach_pin_ff       <= PIN_RESET;
         ppr_ff            <= PPR_RESET;
         window_ff         <= WINDOW_RESET;
         pulse_total_ff    <= '0;
         pulses_at_last_ff <= '0;
         time_at_last_ff   <= '0;
         rpm_held_ff       <= '0;
         upd_ff            <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         tach_pin_ff       <= tach_pin_in;
         ppr_ff            <= ppr_in;
         window_ff         <= window_in;
         pulse_total_ff    <= pulse_total_in;
         pulses_at_last_ff <= pulses_at_last_in;
         time_at_last_ff   <= time_at_last_in;
         rpm_held_ff       <= rpm_held_in;
         upd_ff            <= upd_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      count_ff       <= count_in;
      elapsed_ff     <= elapsed_in;
      now_ff         <= now_in;
      num_ff         <= num_in;
      den_ff         <= den_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef NO_ASSERTIONS
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished outside the wait state");

   a_due_poll_measures: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_payload.cmd == CMD_POLL) && due) |=> (state_ff == ST_MUL))
      else $error("due poll did not start a measurement");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_WAIT) |-> (den_ff != '0))
      else $error("zero divisor in division");

   a_edge_no_update: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_payload.cmd == CMD_EDGE)) |=> (state_ff == ST_DONE) && !upd_ff)
      else $error("edge transaction flagged an update");
`endif

endmodule

// ===== rtl/fan_tach_divider.sv =====
// ----------------------------------------------------------------------------
// fan tach divider
// restoring radix-2 divider, one quotient bit per cycle, shared by all measuring polls
// ----------------------------------------------------------------------------
module fan_tach_divider #(
   parameter int NUM_WIDTH = 48,
   parameter int DEN_WIDTH = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] dividend,
   input  logic [DEN_WIDTH-1:0] divisor,
   output logic                 done,
   output logic [NUM_WIDTH-1:0] quotient
);
   localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [DEN_WIDTH-1:0] rem_ff, rem_in;
   logic [DEN_WIDTH-1:0] div_ff, div_in;
   logic [DEN_WIDTH:0]   trial;
   logic [DEN_WIDTH:0]   diff;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_WIDTH-1]};
      diff    = trial - {1'b0, div_ff};
      fits    = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(NUM_WIDTH);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_WIDTH-2:0], fits};
         rem_in = fits ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== tb/sv/tb_fan_tach_rpm_meter.sv =====
// ----------------------------------------------------------------------------
// fan tach rpm meter testbench
// drives tach edges and millisecond polls through the request channel under
// several register settings and idle patterns, predicts every response with
// an in-bench rpm calculator and checks each response field by field
// ----------------------------------------------------------------------------
module tb_fan_tach_rpm_meter;
   timeunit 1ns;
   timeprecision 1ps;

   import fan_tach_pkg::*;

   localparam int COUNT_WIDTH = COUNT_WIDTH_DEFAULT;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 64;
   localparam int PHASE_ITEMS = 200;
   localparam int BURST_EDGES = 40;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNKNOWN_INDEX = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   req_payload_type pending_reqs[$];
   rsp_payload_type rpm_expected[$];

   int errors = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   logic pressure_go = 1'b0;
   logic hold_off;

   // register shadows
   logic [PIN_WIDTH-1:0] tach_pin_cfg = PIN_RESET;
   logic [PPR_WIDTH-1:0] ppr_cfg = PPR_RESET;
   logic [WIN_WIDTH-1:0] window_cfg = WINDOW_RESET;

   // meter state
   logic [COUNT_WIDTH-1:0] pulse_total = '0;
   logic [COUNT_WIDTH-1:0] pulses_at_last = '0;
   logic [MS_WIDTH-1:0] time_at_last = '0;
   logic [RPM_WIDTH-1:0] rpm_held = '0;

   logic [MS_WIDTH-1:0] sweep_ms = '0;

   fan_tach_rpm_meter uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb_fan_tach_rpm_meter: FAIL");
      $finish;
   end

   function automatic rsp_payload_type rpm_predict(req_payload_type item);
      rsp_payload_type res;
      logic [MS_WIDTH-1:0] elapsed;
      logic [MS_WIDTH-1:0] win_eff;
      logic [PPR_WIDTH-1:0] ppr_eff;
      logic [COUNT_WIDTH-1:0] count;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] quot;
      res.updated = 1'b0;
      if (item.cmd == CMD_EDGE) begin
         if (item.pin == tach_pin_cfg) pulse_total = pulse_total + 1'b1;
      end else begin
         win_eff = (window_cfg == '0) ? 32'd1 : 32'(window_cfg);
         elapsed = item.now_ms - time_at_last;
         if (elapsed >= win_eff) begin
            ppr_eff = (ppr_cfg == '0) ? 8'd1 : ppr_cfg;
            count = pulse_total - pulses_at_last;
            num = 64'(count) * 64'(RPM_MS_PER_MIN);
            den = 64'(elapsed) * 64'(ppr_eff);
            quot = num / den;
            rpm_held = (quot > 64'hFFFF_FFFF) ? '1 : quot[RPM_WIDTH-1:0];
            pulses_at_last = pulse_total;
            time_at_last = item.now_ms;
            res.updated = 1'b1;
         end
      end
      res.rpm = rpm_held;
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) rpm_expected.push_back(rpm_predict(req_payload));
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_payload <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rpm_expected.size() == 0) begin
               $error("unexpected transaction: rpm %0d updated %0b",
                      rsp_payload.rpm, rsp_payload.updated);
               errors++;
            end else begin
               want = rpm_expected.pop_front();
               if (rsp_payload.rpm !== want.rpm) begin
                  $error("rpm: expected %0d actual %0d", want.rpm, rsp_payload.rpm);
                  errors++;
               end
               if (rsp_payload.updated !== want.updated) begin
                  $error("updated: expected %0b actual %0b", want.updated,
                         rsp_payload.updated);
                  errors++;
               end
            end
         end
         rsp_stall <= hold_off || ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // long receiver hold-off so the block backs up
   initial begin
      hold_off = 1'b0;
      wait (pressure_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_TACH_PIN_ID:    tach_pin_cfg = data;
         CSR_PULSES_PER_REV: ppr_cfg = data[PPR_WIDTH-1:0];
         CSR_WINDOW_MS:      window_cfg = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic push_edge(input logic [PIN_WIDTH-1:0] pin);
      req_payload_type item;
      item.cmd = CMD_EDGE;
      item.pin = pin;
      item.now_ms = $urandom();
      pending_reqs.push_back(item);
   endtask

   task automatic push_poll(input logic [MS_WIDTH-1:0] now_ms);
      req_payload_type item;
      item.cmd = CMD_POLL;
      item.pin = 16'($urandom_range(0, 65535));
      item.now_ms = now_ms;
      pending_reqs.push_back(item);
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || rpm_expected.size() != 0)
         @(posedge clock);
   endtask

   // mostly matching edges and polls that step near the window, some noise
   task automatic random_phase(input int idle_pct, input int stall_pct);
      int win;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      win = (window_cfg == '0) ? 1 : int'(window_cfg);
      repeat (PHASE_ITEMS) begin
         if ($urandom_range(0, 5) != 0) begin
            if ($urandom_range(0, 3) != 0) push_edge(tach_pin_cfg);
            else push_edge(16'($urandom_range(0, 65535)));
         end else begin
            if ($urandom_range(0, 7) == 0) sweep_ms = $urandom();
            else sweep_ms = sweep_ms + 32'($urandom_range(0, 2 * win));
            push_poll(sweep_ms);
         end
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // defaults: pin 0, two pulses per rev, 1000 ms window
      push_edge(16'h0000);
      push_edge(16'hFFFF);
      push_poll(32'd999);
      push_poll(32'd1000);
      repeat (3) push_edge(16'h0000);
      push_poll(32'hFFFF_FFFF);
      push_edge(16'h0000);
      push_poll(32'd998);
      push_poll(32'd999);
      drain();

      // zero divisor factor and zero window, unknown index ignored
      csr_write(CSR_TACH_PIN_ID, 16'hFFFF);
      csr_write(CSR_PULSES_PER_REV, 16'h0000);
      csr_write(CSR_WINDOW_MS, 16'h0000);
      csr_write(CSR_UNKNOWN_INDEX, 16'hFFFF);
      push_edge(16'hFFFF);
      push_edge(16'hFFFF);
      push_edge(16'h0000);
      push_poll(32'd1000);
      push_poll(32'd1000);
      drain();

      // a burst of pulses within one ms
      csr_write(CSR_PULSES_PER_REV, 16'hFF01);
      repeat (BURST_EDGES) push_edge(16'hFFFF);
      push_poll(32'd1001);
      push_poll(32'd1002);
      drain();
      sweep_ms = 32'd1002;

      csr_write(CSR_TACH_PIN_ID, 16'h5A3C);
      csr_write(CSR_WINDOW_MS, 16'd1);
      pressure_go = 1'b1;
      random_phase(0, 0);

      csr_write(CSR_TACH_PIN_ID, 16'h0000);
      csr_write(CSR_PULSES_PER_REV, 16'h00FF);
      csr_write(CSR_WINDOW_MS, 16'hFFFF);
      random_phase(74, 0);

      csr_write(CSR_TACH_PIN_ID, 16'($urandom_range(0, 65535)));
      csr_write(CSR_PULSES_PER_REV, 16'($urandom_range(1, 255)));
      csr_write(CSR_WINDOW_MS, 16'($urandom_range(1, 300)));
      random_phase(0, 74);

      csr_write(CSR_TACH_PIN_ID, 16'hC3A5);
      csr_write(CSR_PULSES_PER_REV, 16'd3);
      csr_write(CSR_WINDOW_MS, 16'd16);
      random_phase(14, 14);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && rpm_expected.size() == 0) begin
         $display("tb_fan_tach_rpm_meter: PASS");
      end else begin
         $display("tb_fan_tach_rpm_meter: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/fan_tach_pkg.sv
rtl/fan_tach_divider.sv
rtl/fan_tach_rpm_meter.sv
tb/sv/tb_fan_tach_rpm_meter.sv
